/* design/dpt_pkg.sv */
`timescale 1ns / 1ps

package dpt_pkg;

  localparam int DAMPER_COUNT = 3;
  localparam int POS_W        = 8;

  localparam logic [POS_W-1:0] POS_RESET   = 8'd1;
  localparam logic [POS_W-1:0] POS_TIMEOUT = 8'hFF;
  localparam logic [POS_W-1:0] OPEN_RESET  = 8'd100;
  localparam logic [DAMPER_COUNT-1:0] INSTALLED_RESET = 3'b111;

  // item kinds
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_ENDSTOP  = 2'd1;
  localparam logic [1:0] OP_COMMAND  = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // fan modes
  localparam logic [1:0] FAN_OFF     = 2'd0;
  localparam logic [1:0] FAN_DEMAND  = 2'd1;
  localparam logic [1:0] FAN_ON      = 2'd2;
  localparam logic [1:0] FAN_INVALID = 2'd3;

  // damper commands
  localparam logic [1:0] DCMD_CLOSED   = 2'd0;
  localparam logic [1:0] DCMD_OPEN     = 2'd1;
  localparam logic [1:0] DCMD_HALF     = 2'd2;
  localparam logic [1:0] DCMD_RESERVED = 2'd3;

  // register indexes
  localparam logic [1:0] REG_INSTALLED = 2'd0;
  localparam logic [1:0] REG_OPEN_0    = 2'd1;
  localparam logic [1:0] REG_OPEN_1    = 2'd2;
  localparam logic [1:0] REG_OPEN_2    = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] endstop_low;
    logic [1:0] fan_mode_cmd;
    logic [1:0] damper0_cmd;
    logic [1:0] damper1_cmd;
    logic [1:0] damper2_cmd;
  } item_t;

  typedef struct packed {
    logic [2:0] motor_run;
    logic       fan_run;
    logic [2:0] timeout_flags;
    logic       all_closed;
    logic       at_target;
  } result_t;

  typedef struct packed {
    logic [DAMPER_COUNT-1:0]            installed;
    logic [DAMPER_COUNT-1:0][POS_W-1:0] open_pos;
  } cfg_t;

endpackage

/* design/dpt_cfg.sv */
`timescale 1ns / 1ps

module dpt_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output dpt_pkg::cfg_t cfg
);
  import dpt_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.installed <= INSTALLED_RESET;
      cfg.open_pos  <= {DAMPER_COUNT{OPEN_RESET}};
    end else if (wr_en) begin
      case (reg_index)
        REG_INSTALLED: cfg.installed   <= pwdata[DAMPER_COUNT-1:0];
        REG_OPEN_0:    cfg.open_pos[0] <= pwdata[POS_W-1:0];
        REG_OPEN_1:    cfg.open_pos[1] <= pwdata[POS_W-1:0];
        REG_OPEN_2:    cfg.open_pos[2] <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_INSTALLED: prdata = {29'd0, cfg.installed};
      REG_OPEN_0:    prdata = {24'd0, cfg.open_pos[0]};
      REG_OPEN_1:    prdata = {24'd0, cfg.open_pos[1]};
      REG_OPEN_2:    prdata = {24'd0, cfg.open_pos[2]};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

/* design/dpt_core.sv */
`timescale 1ns / 1ps

module dpt_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  dpt_pkg::item_t   item,
  input  dpt_pkg::cfg_t    cfg,
  output dpt_pkg::result_t result_next
);
  import dpt_pkg::*;

  logic [DAMPER_COUNT-1:0][POS_W-1:0] position, position_next;
  logic [DAMPER_COUNT-1:0][POS_W-1:0] target, target_next;
  logic [DAMPER_COUNT-1:0]            latch, latch_next;
  logic [1:0]                         fan_mode, fan_mode_next;
  logic [DAMPER_COUNT-1:0]            motor_state, motor_state_next;

  logic [DAMPER_COUNT-1:0][1:0] dcmd;
  logic [DAMPER_COUNT-1:0]      tflags;
  logic [POS_W-1:0]             pos_sync;
  logic                         closed;
  logic                         reached;

  assign dcmd = {item.damper2_cmd, item.damper1_cmd, item.damper0_cmd};

  always_comb begin
    position_next    = position;
    target_next      = target;
    latch_next       = latch;
    fan_mode_next    = fan_mode;
    motor_state_next = motor_state;
    tflags           = '0;
    pos_sync         = '0;
    closed           = 1'b1;
    reached          = 1'b1;

    case (item.op)
      OP_TICK: begin
        for (int d = 0; d < DAMPER_COUNT; d++) begin
          if (cfg.installed[d]) begin
            // resync to zero on a latched endstop
            pos_sync      = latch[d] ? '0 : position[d];
            latch_next[d] = 1'b0;
            if (target[d] == '0 && pos_sync == POS_TIMEOUT) begin
              tflags[d] = 1'b1;
            end
            if (pos_sync != target[d]) begin
              motor_state_next[d] = 1'b1;
              position_next[d]    = pos_sync + 8'd1;
            end else begin
              motor_state_next[d] = 1'b0;
              position_next[d]    = pos_sync;
            end
          end
        end
      end
      OP_ENDSTOP: begin
        latch_next = latch | item.endstop_low;
      end
      OP_COMMAND: begin
        fan_mode_next = (item.fan_mode_cmd == FAN_INVALID) ? FAN_OFF : item.fan_mode_cmd;
        for (int d = 0; d < DAMPER_COUNT; d++) begin
          case (dcmd[d])
            DCMD_OPEN: target_next[d] = cfg.open_pos[d];
            DCMD_HALF: target_next[d] = cfg.open_pos[d] >> 1;
            default:   target_next[d] = '0;
          endcase
        end
      end
      default: ;
    endcase

    for (int d = 0; d < DAMPER_COUNT; d++) begin
      if (cfg.installed[d]) begin
        if (position_next[d] != '0) begin
          closed = 1'b0;
        end
        if (position_next[d] != target_next[d]) begin
          reached = 1'b0;
        end
      end
    end

    result_next.motor_run     = motor_state_next;
    result_next.fan_run       = (fan_mode_next != FAN_OFF) && reached && !closed;
    result_next.timeout_flags = tflags;
    result_next.all_closed    = closed;
    result_next.at_target     = reached;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= {DAMPER_COUNT{POS_RESET}};
      target      <= '0;
      latch       <= '0;
      fan_mode    <= FAN_DEMAND;
      motor_state <= '0;
    end else if (fire) begin
      position    <= position_next;
      target      <= target_next;
      latch       <= latch_next;
      fan_mode    <= fan_mode_next;
      motor_state <= motor_state_next;
    end
  end

  // motors change only on ticks
  a_motor_tick_only: assert property (@(posedge clk) disable iff (rst)
    fire && item.op != OP_TICK |=> $stable(motor_state))
    else $error("motor state changed on a non-tick word");

  // commands never move a damper
  a_cmd_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_COMMAND |=> $stable(position))
    else $error("position changed on a command word");

  // timeouts only for installed dampers
  a_timeout_installed: assert property (@(posedge clk) disable iff (rst)
    (result_next.timeout_flags & ~cfg.installed) == '0)
    else $error("timeout flagged on an uninstalled damper");

endmodule

/* design/damper_position_timer_controller_top.sv */
`timescale 1ns / 1ps

// Damper position timer controller.
// Item channel (item_valid / item_stall / item): each word is a timer tick,
// an endstop sample or a command. Result channel (result_valid /
// result_stall / result): exactly one status word per item, in order.
// Configuration goes through the APB port: installed mask at 0x0, open
// positions of dampers 0..2 at 0x4, 0x8, 0xC; write only while idle.
// An accepted item passes through the input register and then the result
// register. Throughput: one item per cycle while the receiver does not
// stall; the input register feeds one pass of update logic that writes both
// the damper state and the result register in the same cycle.
// Reset: positions go to 1 so dampers seek an endstop, targets to 0,
// latches clear, fan mode goes to demand, motors stop, both registers empty.
// When the receiver stalls, the result word holds; the input register can
// still fill, and item_stall rises only once both stages are occupied.
module damper_position_timer_controller_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  dpt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output dpt_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dpt_pkg::*;

  cfg_t    cfg;
  item_t   item_reg;
  logic    item_reg_valid;
  logic    advance;
  logic    fire;
  result_t result_next;

  // the result register frees up when empty or taken this cycle
  assign advance    = !result_valid || !result_stall;
  assign fire       = item_reg_valid && advance;
  assign item_stall = item_reg_valid && !advance;

  dpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item_reg),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // input register: load whenever it is empty or drains this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (!item_stall) begin
      item_reg_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_reg <= item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  // a stall toward the source means a word is held in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    item_stall |=> item_reg_valid)
    else $error("input stall without a held word");

  // hold the held input word while stalled
  a_item_reg_hold: assert property (@(posedge clk) disable iff (rst)
    item_stall |=> $stable(item_reg))
    else $error("held input word changed under stall");

  // hold the result word while the receiver stalls
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed under stall");

endmodule
